@@ design/bfba_pkg.sv @@
// shared types, constants and helpers for the bitmap free-bit allocator
`default_nettype none

package bfba_pkg;

    localparam int MAP_WORDS_DEF   = 128;
    localparam int MAX_REQUEST_DEF = 64;

    localparam int COUNT_W = 7;
    localparam int POS_W   = 12;
    localparam int BYTES_W = 10;
    localparam int WORD_W  = 32;
    localparam int OFFS_W  = 5;

    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 24;
    localparam int APB_AW    = 3;
    localparam int APB_DW    = 32;

    localparam logic [BYTES_W-1:0] MAP_BYTES_RST = 10'd512;

    // register index, taken from paddr[2]
    localparam logic REG_MAP_BYTES = 1'b0;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_LOAD,
        ST_SCAN,
        ST_WRITE,
        ST_CLOSE
    } state_t;

    typedef struct packed {
        logic start;
        logic clr_wr;
        logic rd_en;
        logic load;
        logic emit_pos;
        logic emit_close;
        logic wr_back;
        logic next_word;
    } cmd_t;

    typedef struct packed {
        logic clr_last;
        logic in_range;
        logic count_met;
        logic avail_zero;
        logic out_free;
    } status_t;

    function automatic logic [OFFS_W-1:0] lowest_set(input logic [WORD_W-1:0] v);
        logic [OFFS_W-1:0] r;
        r = OFFS_W'(WORD_W - 1);
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (v[i]) begin
                r = OFFS_W'(i);
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ design/bfba_ram.sv @@
// generic single-write, single-read ram with registered read data
`default_nettype none

module bfba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  wire logic                                  aclk,
    input  wire logic                                  wr_en,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                      wr_data,
    input  wire logic                                  rd_en,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                      rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ design/bfba_ctrl.sv @@
// scan sequencer for the bitmap allocator
`default_nettype none

module bfba_ctrl (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire bfba_pkg::status_t sts,
    output bfba_pkg::cmd_t        cmd
);

    bfba_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= bfba_pkg::ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            bfba_pkg::ST_CLEAR: begin
                if (sts.clr_last) state_next = bfba_pkg::ST_IDLE;
            end
            bfba_pkg::ST_IDLE: begin
                if (s_tvalid) state_next = bfba_pkg::ST_READ;
            end
            bfba_pkg::ST_READ: begin
                if (!sts.in_range || sts.count_met) state_next = bfba_pkg::ST_CLOSE;
                else state_next = bfba_pkg::ST_LOAD;
            end
            bfba_pkg::ST_LOAD: begin
                state_next = bfba_pkg::ST_SCAN;
            end
            bfba_pkg::ST_SCAN: begin
                if (sts.avail_zero || sts.count_met) state_next = bfba_pkg::ST_WRITE;
            end
            bfba_pkg::ST_WRITE: begin
                if (sts.count_met) state_next = bfba_pkg::ST_IDLE;
                else state_next = bfba_pkg::ST_READ;
            end
            bfba_pkg::ST_CLOSE: begin
                if (sts.out_free) state_next = bfba_pkg::ST_IDLE;
            end
            default: state_next = bfba_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            bfba_pkg::ST_CLEAR: begin
                cmd.clr_wr = 1'b1;
            end
            bfba_pkg::ST_IDLE: begin
                s_tready  = 1'b1;
                cmd.start = s_tvalid;
            end
            bfba_pkg::ST_READ: begin
                cmd.rd_en = sts.in_range && !sts.count_met;
            end
            bfba_pkg::ST_LOAD: begin
                cmd.load = 1'b1;
            end
            bfba_pkg::ST_SCAN: begin
                cmd.emit_pos = !sts.avail_zero && !sts.count_met && sts.out_free;
            end
            bfba_pkg::ST_WRITE: begin
                cmd.wr_back   = 1'b1;
                cmd.next_word = !sts.count_met;
            end
            bfba_pkg::ST_CLOSE: begin
                cmd.emit_close = sts.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ design/bfba_dp.sv @@
// word pointer, scan registers, bitmap ram and result register
`default_nettype none

module bfba_dp #(
    parameter int MAP_WORDS   = bfba_pkg::MAP_WORDS_DEF,
    parameter int MAX_REQUEST = bfba_pkg::MAX_REQUEST_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire bfba_pkg::cmd_t                    cmd,
    output bfba_pkg::status_t                      sts,
    input  wire logic [bfba_pkg::COUNT_W-1:0]      request_count,
    input  wire logic [bfba_pkg::BYTES_W-1:0]      map_bytes,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic                                   position_valid,
    output logic      [bfba_pkg::POS_W-1:0]        bit_position,
    output logic                                   last,
    output logic      [bfba_pkg::COUNT_W-1:0]      shortfall
);

    localparam int AW = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int WW = AW + 1;
    localparam int CW = (WW > 8) ? WW : 8;
    localparam int MAP_BYTES_MAX = MAP_WORDS * 4;

    logic [WW-1:0]                   w_reg;
    logic [bfba_pkg::COUNT_W-1:0]    count_reg, found_reg;
    logic [bfba_pkg::BYTES_W-1:0]    bytes_reg;
    logic [bfba_pkg::WORD_W-1:0]     word_reg, avail_reg;
    logic                            m_valid_reg;
    logic                            m_pv_reg, m_last_reg;
    logic [bfba_pkg::POS_W-1:0]      m_pos_reg;
    logic [bfba_pkg::COUNT_W-1:0]    m_short_reg;

    logic [bfba_pkg::WORD_W-1:0]     rd_data, wr_data, mask;
    logic [bfba_pkg::OFFS_W-1:0]     offs;
    logic [CW-1:0]                   wx, fx;
    logic [1:0]                      tail;
    logic                            below_full, out_free;
    logic [bfba_pkg::COUNT_W-1:0]    count_sat, found_inc;
    logic [bfba_pkg::BYTES_W-1:0]    bytes_clip;

    assign count_sat = (request_count > bfba_pkg::COUNT_W'(MAX_REQUEST))
                     ? bfba_pkg::COUNT_W'(MAX_REQUEST) : request_count;
    assign bytes_clip = ({22'd0, map_bytes} > 32'(MAP_BYTES_MAX))
                      ? bfba_pkg::BYTES_W'(MAP_BYTES_MAX) : map_bytes;

    // word w covers bytes 4w..4w+3; the tail word holds only the leftover bytes
    assign wx         = CW'(w_reg);
    assign fx         = CW'(bytes_reg[bfba_pkg::BYTES_W-1:2]);
    assign tail       = bytes_reg[1:0];
    assign below_full = wx < fx;

    always_comb begin
        if (below_full) begin
            mask = '1;
        end else begin
            case (tail)
                2'd1:    mask = 32'h0000_00ff;
                2'd2:    mask = 32'h0000_ffff;
                2'd3:    mask = 32'h00ff_ffff;
                default: mask = '0;
            endcase
        end
    end

    assign offs      = bfba_pkg::lowest_set(avail_reg);
    assign found_inc = found_reg + 7'd1;
    assign out_free  = !m_valid_reg || m_ready;
    assign wr_data   = cmd.clr_wr ? '0 : word_reg;

    assign sts.clr_last   = (w_reg[AW-1:0] == AW'(MAP_WORDS - 1));
    assign sts.in_range   = below_full || (wx == fx && tail != 2'd0);
    assign sts.count_met  = (found_reg == count_reg);
    assign sts.avail_zero = (avail_reg == '0);
    assign sts.out_free   = out_free;

    bfba_ram #(
        .WIDTH (bfba_pkg::WORD_W),
        .DEPTH (MAP_WORDS)
    ) u_map (
        .aclk    (aclk),
        .wr_en   (cmd.clr_wr || cmd.wr_back),
        .wr_addr (w_reg[AW-1:0]),
        .wr_data (wr_data),
        .rd_en   (cmd.rd_en),
        .rd_addr (w_reg[AW-1:0]),
        .rd_data (rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            w_reg     <= '0;
            count_reg <= '0;
            found_reg <= '0;
        end else begin
            if (cmd.start) begin
                w_reg     <= '0;
                count_reg <= count_sat;
                found_reg <= '0;
            end else if (cmd.clr_wr) begin
                w_reg <= sts.clr_last ? '0 : w_reg + WW'(1);
            end else if (cmd.next_word) begin
                w_reg <= w_reg + WW'(1);
            end
            if (cmd.emit_pos) begin
                found_reg <= found_inc;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            bytes_reg <= bytes_clip;
        end
        if (cmd.load) begin
            word_reg  <= rd_data;
            avail_reg <= ~rd_data & mask;
        end else if (cmd.emit_pos) begin
            word_reg[offs]  <= 1'b1;
            avail_reg[offs] <= 1'b0;
        end
    end

    // result register, free once the current beat is taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit_pos || cmd.emit_close) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit_pos) begin
            m_pv_reg    <= 1'b1;
            m_pos_reg   <= bfba_pkg::POS_W'({w_reg[AW-1:0], offs});
            m_last_reg  <= (found_inc == count_reg);
            m_short_reg <= '0;
        end else if (cmd.emit_close) begin
            m_pv_reg    <= 1'b0;
            m_pos_reg   <= '0;
            m_last_reg  <= 1'b1;
            m_short_reg <= count_reg - found_reg;
        end
    end

    assign m_valid        = m_valid_reg;
    assign position_valid = m_pv_reg;
    assign bit_position   = m_pos_reg;
    assign last           = m_last_reg;
    assign shortfall      = m_short_reg;

    a_found_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        found_reg <= count_reg)
        else $error("found count ran past the request");

    a_emit_has_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit_pos || cmd.emit_close) |-> out_free)
        else $error("result written over an untaken beat");

    a_emit_free_bit: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit_pos |-> (avail_reg[offs] && !word_reg[offs]))
        else $error("allocated a bit that was not free");

    a_close_short: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit_close |=> (m_valid_reg && m_last_reg && !m_pv_reg))
        else $error("closing beat malformed");

endmodule

`default_nettype wire

@@ design/bitmap_free_bit_allocator.sv @@
// top level of the bitmap free-bit allocator: apb register, sequencer and datapath
`default_nettype none

// Bitmap free-bit allocator. A set bit in the map means used; the map is cleared to all
// free at reset by a clearing pass over every word, during which s_tready stays low
// (register writes are taken as usual). Each request beat carries a count, saturated to
// MAX_REQUEST; the block scans 32-bit words from word 0 upward, lowest bit first, within
// the first map_bytes bytes, marks each free bit it finds as used and returns one beat per
// allocated bit. If the count cannot be met, or is zero, a closing beat with
// position_valid low and the shortfall follows. For each word visited the block reads the
// map ram, loads the word, scans it and writes it back; the priority pick in the scan
// allocates one bit per cycle while the result register is free, and each stalled result
// beat holds the scan. When a closing beat follows, a range check in the read state comes
// before it. The map ram is read one word at a time. A new request is taken only once the
// previous one has put its last beat into the output register.
module bitmap_free_bit_allocator #(
    parameter int MAP_WORDS   = bfba_pkg::MAP_WORDS_DEF,
    parameter int MAX_REQUEST = bfba_pkg::MAX_REQUEST_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // request_count [6:0]
    input  wire logic [bfba_pkg::S_TDATA_W-1:0]  s_tdata,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // position_valid [0], bit_position [12:1], shortfall [19:13]
    output logic      [bfba_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic                                 m_tlast,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [bfba_pkg::APB_AW-1:0]     paddr,
    input  wire logic [bfba_pkg::APB_DW-1:0]     pwdata,
    output logic      [bfba_pkg::APB_DW-1:0]     prdata,
    output logic                                 pready
);

    logic [bfba_pkg::BYTES_W-1:0] map_bytes_reg;
    bfba_pkg::cmd_t               cmd;
    bfba_pkg::status_t            sts;
    logic                         pos_valid;
    logic [bfba_pkg::POS_W-1:0]   bit_pos;
    logic [bfba_pkg::COUNT_W-1:0] short_cnt;

    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            map_bytes_reg <= bfba_pkg::MAP_BYTES_RST;
        end else if (psel && penable && pwrite && paddr[2] == bfba_pkg::REG_MAP_BYTES) begin
            map_bytes_reg <= pwdata[bfba_pkg::BYTES_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == bfba_pkg::REG_MAP_BYTES) begin
            prdata = bfba_pkg::APB_DW'(map_bytes_reg);
        end
    end

    bfba_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    bfba_dp #(
        .MAP_WORDS   (MAP_WORDS),
        .MAX_REQUEST (MAX_REQUEST)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .sts            (sts),
        .request_count  (s_tdata[bfba_pkg::COUNT_W-1:0]),
        .map_bytes      (map_bytes_reg),
        .m_valid        (m_tvalid),
        .m_ready        (m_tready),
        .position_valid (pos_valid),
        .bit_position   (bit_pos),
        .last           (m_tlast),
        .shortfall      (short_cnt)
    );

    assign m_tdata = {4'd0, short_cnt, bit_pos, pos_valid};

endmodule

`default_nettype wire
